// ===== rtl/csvft_pkg.sv =====
// Shared types, codes and constants of the CSV field tokenizer.
`timescale 1ns / 1ps

package csvft_pkg;

    // Highest field index the counter can reach; the count stops there.
    localparam int MAX_FIELD_INDEX = 255;
    localparam logic [7:0] FIELD_LIMIT =
        (MAX_FIELD_INDEX > 255) ? 8'd255 : 8'(MAX_FIELD_INDEX);

    // Input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    // Result kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam logic REG_SEPARATOR = 1'b0;
    localparam logic REG_QUOTE     = 1'b1;

    localparam logic [7:0] SEPARATOR_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;
    localparam logic [7:0] CHAR_CR         = 8'd13;
    localparam logic [7:0] CHAR_LF         = 8'd10;

    typedef struct packed {
        logic       inside_quotes;
        logic       quote_pending;
        logic [7:0] field_counter;
    } tok_state_t;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] out_byte;
        logic [7:0] field_index;
        logic       line_last;
    } tok_result_t;

endpackage

// ===== rtl/csvft_step.sv =====
// Next-state and result logic for one tokenizer input item.
`timescale 1ns / 1ps

module csvft_step (
    input  logic                 op,
    input  logic [7:0]           data_byte,
    input  logic [7:0]           separator_char,
    input  logic [7:0]           quote_char,
    input  csvft_pkg::tok_state_t  state_cur,
    output csvft_pkg::tok_state_t  state_nxt,
    output csvft_pkg::tok_result_t result
);
    import csvft_pkg::*;

    logic is_quote;
    logic is_sep;
    logic is_break;
    logic inq_eff;

    assign is_quote = (data_byte == quote_char);
    assign is_sep   = (data_byte == separator_char);
    assign is_break = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);
    // a pending quote not followed by another quote closes the section
    assign inq_eff  = state_cur.inside_quotes && !state_cur.quote_pending;

    always_comb begin
        state_nxt          = state_cur;
        result.valid       = 1'b0;
        result.kind        = KIND_CHAR;
        result.out_byte    = data_byte;
        result.field_index = state_cur.field_counter;
        result.line_last   = 1'b0;

        if (op == OP_EOL) begin
            result.valid  = 1'b1;
            result.kind   = KIND_END;
            result.out_byte = 8'd0;
            result.line_last = 1'b1;
            state_nxt.inside_quotes = 1'b0;
            state_nxt.quote_pending = 1'b0;
            state_nxt.field_counter = 8'd0;
        end else if (state_cur.quote_pending && is_quote) begin
            // doubled quote: one literal quote, stay inside
            state_nxt.quote_pending = 1'b0;
            result.valid = 1'b1;
        end else begin
            state_nxt.quote_pending = 1'b0;
            state_nxt.inside_quotes = inq_eff;
            if (is_quote) begin
                if (inq_eff) begin
                    state_nxt.quote_pending = 1'b1;
                end else begin
                    state_nxt.inside_quotes = 1'b1;
                end
            end else if (!inq_eff && is_sep) begin
                result.valid    = 1'b1;
                result.kind     = KIND_END;
                result.out_byte = 8'd0;
                if (state_cur.field_counter < FIELD_LIMIT) begin
                    state_nxt.field_counter = state_cur.field_counter + 8'd1;
                end
            end else if (!inq_eff && is_break) begin
                result.valid = 1'b0;
            end else begin
                result.valid = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/csv_field_tokenizer.sv =====
// Top level of the streaming CSV field tokenizer with APB register port.
`timescale 1ns / 1ps

// Streaming CSV tokenizer. Each input transfer carries one line byte
// (s_tuser = 0) or an end-of-line mark (s_tuser = 1). Every transfer is
// handled in one step: the quote/pending flags and the field counter sit in
// one register, the decision logic in front of it is a few byte compares,
// and the result lands in an output register. Throughput is one transfer per
// cycle unless the output stalls; results show in the next cycle. The input
// stays ready while the output register is empty or being drained, so a
// stall on m_tready stops the input only in the same cycle. A transfer may
// produce no result (quotes, CR/LF outside quotes). Results: m_tuser = 0 is
// a field character in m_tdata[7:0], m_tuser = 1 is a field end; m_tlast
// marks the field end that closes the line. m_tdata[15:8] is the field index
// within the line, saturating at 255. Registers: separator at 0x0 (reset
// comma), quote at 0x4 (reset double quote); write them only while idle.

module csv_field_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] op (0 byte, 1 end of line)
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] field_index
    output logic        m_tuser,   // [0] kind (0 char, 1 field end)
    output logic        m_tlast,   // line_last
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import csvft_pkg::*;

    logic [7:0]  separator_reg;
    logic [7:0]  quote_reg;
    tok_state_t  state_reg;
    tok_state_t  state_next;
    tok_result_t step_res;
    tok_result_t out_reg;
    logic        in_xfer;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register index is paddr[2]; low address bits are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            separator_reg <= SEPARATOR_RESET;
            quote_reg     <= QUOTE_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_SEPARATOR) begin
                separator_reg <= pwdata[7:0];
            end else begin
                quote_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_QUOTE) ? {24'd0, quote_reg} : {24'd0, separator_reg};

    csvft_step u_step (
        .op             (s_tuser),
        .data_byte      (s_tdata),
        .separator_char (separator_reg),
        .quote_char     (quote_reg),
        .state_cur      (state_reg),
        .state_nxt      (state_next),
        .result         (step_res)
    );

    // output register frees up in the same cycle it is drained
    assign s_tready = !out_reg.valid || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_reg.valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                state_reg <= state_next;
                // payload needs no reset
                out_reg.kind        <= step_res.kind;
                out_reg.out_byte    <= step_res.out_byte;
                out_reg.field_index <= step_res.field_index;
                out_reg.line_last   <= step_res.line_last;
            end
            if (s_tready) begin
                out_reg.valid <= in_xfer && step_res.valid;
            end
        end
    end

    assign m_tvalid = out_reg.valid;
    assign m_tdata  = {out_reg.field_index, out_reg.out_byte};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.line_last;

    // a pending quote only exists inside a quoted section
    a_pending_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.quote_pending |-> state_reg.inside_quotes)
        else $error("quote pending outside quotes");

    // end of line restarts the line outside quotes at field zero
    a_eol_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_tuser == OP_EOL) |=>
            (state_reg.field_counter == 8'd0 && !state_reg.inside_quotes))
        else $error("end of line did not clear state");

    // end of line always yields a line-closing field end
    a_eol_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_tuser == OP_EOL) |=>
            (m_tvalid && m_tlast && m_tuser == KIND_END))
        else $error("end of line gave no closing field end");

    // a line close is a field end with zero byte
    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == KIND_END && m_tdata[7:0] == 8'd0))
        else $error("line close not a clean field end");

endmodule

// ===== tb/csv_field_tokenizer_tb.sv =====
// Self-checking testbench for the streaming CSV field tokenizer.
`timescale 1ns / 1ps

// Drives byte and end-of-line transfers into the tokenizer and checks every
// result transfer against an in-bench tokenizer model, field by field.
//
// Flow: reset, then directed lines with the default comma/double-quote
// setup, then directed lines with odd separator choices (separator equal to
// the quote, to CR, to LF). After that comes one very long line that drives
// the field index into saturation. The bulk is random CSV lines under
// several separator/quote settings, including the 0x00/0xFF extremes.
// Random lines are mostly well formed: plain fields, quoted fields with
// embedded separators, line breaks and doubled quotes. A few transfers are
// noise, and a few quoted fields are left unterminated.
//
// Both streams idle at random, the sink about 1 cycle in 5. One phase runs
// with no idling at all. The sender drains the pipe now and then, and always
// before a register write, since the registers may only change while idle.

module csv_field_tokenizer_tb;
    import csvft_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;   // cycles with no transfer at all

    // Expected result transfer, one per emitted token
    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [7:0] field_index;
        logic       line_last;
    } token_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // [7:0] data_byte
    logic        s_tuser  = 1'b0;  // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [7:0] out_byte, [15:8] field_index
    logic        m_tuser;          // [0] kind
    logic        m_tlast;          // line_last
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Tokenizer model state and its copy of the registers
    logic        quoted_now = 1'b0;
    logic        quote_held = 1'b0;   // quote seen inside quotes, not yet resolved
    logic [7:0]  field_cnt  = '0;
    logic [7:0]  sep_char   = SEPARATOR_RESET;
    logic [7:0]  quote_char = QUOTE_RESET;

    token_t      expected_tokens[$];
    logic        idle_en      = 1'b1;
    int          errors       = 0;
    int          items_sent   = 0;
    int          results_seen = 0;
    int          stall_cycles = 0;

    csv_field_tokenizer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Model of one accepted input transfer; queues the token it produces.
    task automatic tokenize_step(input logic op, input logic [7:0] b);
        token_t tok;
        logic   has_token;
        logic   resolved;
        tok             = '0;
        tok.field_index = field_cnt;   // index before any separator bump
        has_token       = 1'b0;
        resolved        = 1'b0;
        if (op == OP_EOL) begin
            // closes the last field; every line starts outside quotes
            tok.kind      = KIND_END;
            tok.line_last = 1'b1;
            has_token     = 1'b1;
            quoted_now    = 1'b0;
            quote_held    = 1'b0;
            field_cnt     = '0;
        end else begin
            if (quote_held) begin
                quote_held = 1'b0;
                if (b == quote_char) begin
                    // doubled quote -> one literal quote, still quoted
                    tok.kind     = KIND_CHAR;
                    tok.out_byte = b;
                    has_token    = 1'b1;
                    resolved     = 1'b1;
                end else begin
                    quoted_now = 1'b0;
                end
            end
            if (!resolved) begin
                if (b == quote_char) begin
                    if (quoted_now)
                        quote_held = 1'b1;
                    else
                        quoted_now = 1'b1;
                end else if (!quoted_now && b == sep_char) begin
                    tok.kind  = KIND_END;
                    has_token = 1'b1;
                    if (field_cnt < FIELD_LIMIT)
                        field_cnt = field_cnt + 8'd1;
                end else if (!quoted_now && (b == CHAR_CR || b == CHAR_LF)) begin
                    // bare line break outside quotes: dropped
                end else begin
                    tok.kind     = KIND_CHAR;
                    tok.out_byte = b;
                    has_token    = 1'b1;
                end
            end
        end
        if (has_token)
            expected_tokens.insert(expected_tokens.size(), tok);
    endtask

    // Sends one input transfer; returns at the edge where it is accepted.
    // tvalid stays high on return so back-to-back transfers need no toggle.
    task automatic send_item(input logic op, input logic [7:0] b);
        if (idle_en && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tokenize_step(op, b);
        items_sent++;
    endtask

    // Sender pauses until all expected tokens are back, plus latency slack
    // for a transfer that may still be in flight without a result.
    task automatic drain_tokens();
        s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write: setup then access; upper data bits are junk, must be masked.
    task automatic write_reg(input logic idx, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SEPARATOR)
            sep_char = v;
        else
            quote_char = v;
    endtask

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
                 $realtime, what, results_seen, exp_v, got_v);
        errors++;
    endtask

    // Random field byte that has no special meaning under current settings
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == sep_char || b == quote_char || b == CHAR_CR || b == CHAR_LF);
        return b;
    endfunction

    // One CSV line: plain and quoted fields, optional CRLF, end-of-line mark.
    task automatic send_random_line();
        int n_fields;
        int len;
        n_fields = $urandom_range(1, 6);
        for (int f = 0; f < n_fields; f++) begin
            if (f != 0)
                send_item(OP_BYTE, sep_char);
            len = $urandom_range(0, 5);
            if ($urandom_range(0, 2) == 0) begin
                send_item(OP_BYTE, quote_char);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(0, 7))
                        0: begin
                            send_item(OP_BYTE, quote_char);
                            send_item(OP_BYTE, quote_char);
                        end
                        1: send_item(OP_BYTE, sep_char);
                        2: send_item(OP_BYTE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
                        default: send_item(OP_BYTE, plain_byte());
                    endcase
                end
                // now and then the quote never closes before end of line
                if ($urandom_range(0, 9) != 0)
                    send_item(OP_BYTE, quote_char);
            end else begin
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 11) == 0)
                        send_item($urandom_range(0, 1) ? OP_EOL : OP_BYTE,
                                  8'($urandom_range(0, 255)));
                    else
                        send_item(OP_BYTE, plain_byte());
                end
            end
        end
        if ($urandom_range(0, 1)) begin
            send_item(OP_BYTE, CHAR_CR);
            send_item(OP_BYTE, CHAR_LF);
        end
        send_item(OP_EOL, 8'($urandom_range(0, 255)));
    endtask

    // Default comma / double quote: quoting cases, CR/LF, byte extremes
    task automatic test_default_quoting();
        send_item(OP_EOL, 8'hFF);          // empty line -> one empty field
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, sep_char);
        send_item(OP_BYTE, quote_char);    // enter quotes
        send_item(OP_BYTE, sep_char);      // separator inside quotes is data
        send_item(OP_BYTE, CHAR_CR);       // CR inside quotes is data
        send_item(OP_BYTE, quote_char);
        send_item(OP_BYTE, quote_char);    // doubled -> literal quote
        send_item(OP_BYTE, quote_char);
        send_item(OP_BYTE, 8'hFF);         // held quote closes, FF is outside
        send_item(OP_BYTE, CHAR_CR);       // dropped
        send_item(OP_BYTE, CHAR_LF);       // dropped
        send_item(OP_BYTE, quote_char);
        send_item(OP_BYTE, quote_char);
        send_item(OP_EOL, 8'h00);          // held quote at end of line
    endtask

    // Separator colliding with the quote or with a line-break byte
    task automatic test_separator_collisions();
        drain_tokens();
        write_reg(REG_SEPARATOR, QUOTE_RESET);   // quote meaning wins
        send_item(OP_BYTE, quote_char);
        send_item(OP_BYTE, 8'h61);
        send_item(OP_BYTE, quote_char);
        send_item(OP_BYTE, quote_char);
        send_item(OP_EOL, 8'h5A);
        drain_tokens();
        write_reg(REG_SEPARATOR, CHAR_CR);       // separator meaning wins
        send_item(OP_BYTE, 8'h62);
        send_item(OP_BYTE, CHAR_CR);
        send_item(OP_BYTE, CHAR_LF);
        send_item(OP_EOL, 8'hA5);
        drain_tokens();
        write_reg(REG_SEPARATOR, CHAR_LF);
        send_item(OP_BYTE, CHAR_LF);
        send_item(OP_BYTE, CHAR_CR);
        send_item(OP_EOL, 8'h00);
    endtask

    // Far more fields than the index can count; index must stick at the top
    task automatic test_field_saturation();
        drain_tokens();
        write_reg(REG_SEPARATOR, SEPARATOR_RESET);
        for (int i = 0; i < 262; i++) begin
            if (i % 37 == 0)
                send_item(OP_BYTE, plain_byte());
            send_item(OP_BYTE, sep_char);
        end
        send_item(OP_BYTE, plain_byte());
        send_item(OP_EOL, 8'($urandom_range(0, 255)));
    endtask

    // Random lines under several register settings, extremes included
    task automatic test_random_lines();
        logic [7:0] sep_v;
        logic [7:0] quote_v;
        int         phase_start;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    sep_v   = SEPARATOR_RESET;
                    quote_v = QUOTE_RESET;
                end
                1: begin
                    sep_v   = 8'h00;
                    quote_v = 8'hFF;
                end
                2: begin
                    sep_v   = 8'hFF;
                    quote_v = 8'h00;
                end
                3: begin
                    sep_v   = 8'h3B;   // semicolon / single quote
                    quote_v = 8'h27;
                end
                default: begin
                    sep_v   = 8'($urandom_range(0, 255));
                    quote_v = 8'($urandom_range(0, 255));
                end
            endcase
            idle_en = (p != 3);        // one phase at full rate on both sides
            drain_tokens();
            write_reg(REG_SEPARATOR, sep_v);
            write_reg(REG_QUOTE, quote_v);
            phase_start = items_sent;
            while (items_sent - phase_start < 110) begin
                send_random_line();
                if ($urandom_range(0, 14) == 0)
                    drain_tokens();
            end
        end
        idle_en = 1'b1;
    endtask

    // Result sink: random backpressure when idling is on
    always @(posedge aclk) begin
        m_tready <= !idle_en || ($urandom_range(0, 99) >= 20);
    end

    // Result checker: each result transfer against the oldest expectation
    always @(posedge aclk) begin : check_tokens
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch("unexpected transfer, tdata", -1, int'(m_tdata));
            end else begin
                want = expected_tokens.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", int'(want.kind), int'(m_tuser));
                if (m_tdata[7:0] !== want.out_byte)
                    report_mismatch("out_byte", int'(want.out_byte), int'(m_tdata[7:0]));
                if (m_tdata[15:8] !== want.field_index)
                    report_mismatch("field_index", int'(want.field_index),
                                    int'(m_tdata[15:8]));
                if (m_tlast !== want.line_last)
                    report_mismatch("line_last", int'(want.line_last), int'(m_tlast));
            end
            results_seen++;
        end
    end

    // Watchdog: too long with no transfer on either stream means a hang
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_quoting();
        test_separator_collisions();
        test_field_saturation();
        test_random_lines();
        drain_tokens();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== csv_field_tokenizer.f =====
rtl/csvft_pkg.sv
rtl/csvft_step.sv
rtl/csv_field_tokenizer.sv
tb/csv_field_tokenizer_tb.sv
